[design/bmre_pkg.sv]
// shared types and constants of the boot mouse report decoder
// used by the controller, the datapath, the top level and the checker

package bmre_pkg;

  localparam int NumButtons  = 5;
  localparam int ReportBytes = 3;
  localparam int IdxW        = $clog2(NumButtons);
  localparam int HeldW       = 3;
  localparam int LenW        = 7;
  localparam int DeltaW      = 8;
  localparam int IndexW      = 3;

  localparam logic [7:0] ErrorLimitReset = 8'd20;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DETACH = 2'd1,
    ST_ERROR  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EV_BUTTON = 2'd0,
    EV_MOVE   = 2'd1,
    EV_STOP   = 2'd2
  } event_kind_e;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        eval_good;
    logic        err_inc;
    logic        stop_set;
    logic        idx_inc;
    logic        emit;
    event_kind_e emit_kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       running;
    logic [1:0] status;
    logic       short_len;
    logic       err_stop;
    logic       chg_bit;
    logic       idx_end;
    logic       has_move;
    logic       slot_free;
  } ctrl_stat_t;

endpackage

[design/bmre_ctrl.sv]
// controller of the boot mouse report decoder: sequences one report word
// depends on bmre_pkg for the command and status structs

module bmre_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bmre_pkg::ctrl_stat_t stat_i,
  output bmre_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_BTN,
    S_MOVE,
    S_STOP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.emit_kind = bmre_pkg::EV_BUTTON;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.running) begin
          state_d = S_IDLE;
        end else begin
          case (stat_i.status)
            bmre_pkg::ST_OK: begin
              if (stat_i.short_len) begin
                state_d = S_IDLE;
              end else begin
                cmd_o.eval_good = 1'b1;
                state_d         = S_BTN;
              end
            end
            bmre_pkg::ST_DETACH: begin
              cmd_o.stop_set = 1'b1;
              state_d        = S_STOP;
            end
            default: begin
              // other error, and the unused code too
              cmd_o.err_inc = 1'b1;
              if (stat_i.err_stop) begin
                cmd_o.stop_set = 1'b1;
                state_d        = S_STOP;
              end else begin
                state_d = S_IDLE;
              end
            end
          endcase
        end
      end
      S_BTN: begin
        if (!stat_i.chg_bit || stat_i.slot_free) begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.emit    = stat_i.chg_bit;
          if (stat_i.idx_end) begin
            state_d = stat_i.has_move ? S_MOVE : S_IDLE;
          end
        end
      end
      S_MOVE: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = bmre_pkg::EV_MOVE;
          state_d         = S_IDLE;
        end
      end
      S_STOP: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = bmre_pkg::EV_STOP;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/bmre_dp.sv]
// datapath of the boot mouse report decoder: input latch, button and error
// state, button scan index and output register; depends on bmre_pkg

module bmre_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [7:0]                    cfg_wdata_i,
  input  logic [1:0]                    status_i,
  input  logic [bmre_pkg::LenW-1:0]     actual_length_i,
  input  logic [7:0]                    new_buttons_i,
  input  logic signed [bmre_pkg::DeltaW-1:0] delta_x_i,
  input  logic signed [bmre_pkg::DeltaW-1:0] delta_y_i,
  input  bmre_pkg::ctrl_cmd_t           cmd_i,
  output bmre_pkg::ctrl_stat_t          stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [1:0]                    event_kind_o,
  output logic [bmre_pkg::IndexW-1:0]   button_index_o,
  output logic                          pressed_o,
  output logic [bmre_pkg::HeldW-1:0]    held_flags_o,
  output logic signed [bmre_pkg::DeltaW-1:0] move_x_o,
  output logic signed [bmre_pkg::DeltaW-1:0] move_y_o,
  output logic                          last_o
);

  localparam int Nb = bmre_pkg::NumButtons;
  localparam int Iw = bmre_pkg::IdxW;
  localparam int Hw = bmre_pkg::HeldW;
  localparam int Dw = bmre_pkg::DeltaW;

  // latched input word
  logic [1:0]                   status_q;
  logic [bmre_pkg::LenW-1:0]    len_q;
  logic [Nb-1:0]                nb_q;
  logic signed [Dw-1:0]         dx_q, dy_q;

  // block state
  logic [Nb-1:0] prev_q;
  logic [Nb-1:0] chg_q;
  logic [Hw-1:0] held_q, held_d;
  logic [7:0]    err_q, err_inc;
  logic          running_q;
  logic [7:0]    limit_q;
  logic [Iw-1:0] idx_q;

  // output register
  logic                        out_valid_q;
  logic [1:0]                  kind_q;
  logic [bmre_pkg::IndexW-1:0] index_q;
  logic                        pressed_q;
  logic [Hw-1:0]               flags_q;
  logic signed [Dw-1:0]        mx_q, my_q;
  logic                        last_q;

  logic          has_move;
  logic          slot_free;
  logic [Nb-1:0] chg_hi;
  logic          btn_last;

  assign err_inc   = (err_q == 8'hFF) ? err_q : err_q + 8'd1;
  assign has_move  = (dx_q != '0) || (dy_q != '0);
  assign slot_free = !out_valid_q || out_ready_i;
  // further changed buttons above the current one
  assign chg_hi    = chg_q >> idx_q;
  assign btn_last  = !(|chg_hi[Nb-1:1]) && !has_move;

  assign stat_o.running   = running_q;
  assign stat_o.status    = status_q;
  assign stat_o.short_len = len_q < bmre_pkg::LenW'(bmre_pkg::ReportBytes);
  assign stat_o.err_stop  = err_inc >= limit_q;
  assign stat_o.chg_bit   = chg_q[idx_q];
  assign stat_o.idx_end   = idx_q == Iw'(Nb - 1);
  assign stat_o.has_move  = has_move;
  assign stat_o.slot_free = slot_free;

  // held flags after the update of the current button
  always_comb begin
    held_d = held_q;
    for (int j = 0; j < Hw; j++) begin
      if (idx_q == Iw'(j)) begin
        held_d[j] = nb_q[idx_q];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q <= status_i;
      len_q    <= actual_length_i;
      nb_q     <= new_buttons_i[Nb-1:0];
      dx_q     <= delta_x_i;
      dy_q     <= delta_y_i;
    end
    if (cmd_i.eval_good) begin
      chg_q <= nb_q ^ prev_q;
    end
    if (cmd_i.emit) begin
      kind_q <= cmd_i.emit_kind;
      case (cmd_i.emit_kind)
        bmre_pkg::EV_BUTTON: begin
          index_q   <= bmre_pkg::IndexW'(idx_q);
          pressed_q <= nb_q[idx_q];
          flags_q   <= held_d;
          mx_q      <= '0;
          my_q      <= '0;
          last_q    <= btn_last;
        end
        bmre_pkg::EV_MOVE: begin
          index_q   <= '0;
          pressed_q <= 1'b0;
          flags_q   <= held_q;
          mx_q      <= dx_q;
          my_q      <= dy_q;
          last_q    <= 1'b1;
        end
        default: begin
          index_q   <= '0;
          pressed_q <= 1'b0;
          flags_q   <= held_q;
          mx_q      <= '0;
          my_q      <= '0;
          last_q    <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      held_q      <= '0;
      err_q       <= '0;
      running_q   <= 1'b1;
      limit_q     <= bmre_pkg::ErrorLimitReset;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.eval_good) begin
        prev_q <= nb_q;
        err_q  <= '0;
        idx_q  <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + Iw'(1);
      end
      if (cmd_i.err_inc) begin
        err_q <= err_inc;
      end
      if (cmd_i.stop_set) begin
        running_q <= 1'b0;
      end
      if (cmd_i.emit && cmd_i.emit_kind == bmre_pkg::EV_BUTTON) begin
        held_q <= held_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_kind_o   = kind_q;
  assign button_index_o = index_q;
  assign pressed_o      = pressed_q;
  assign held_flags_o   = flags_q;
  assign move_x_o       = mx_q;
  assign move_y_o       = my_q;
  assign last_o         = last_q;

endmodule

[design/boot_mouse_report_to_events.sv]
// top level of the boot mouse report decoder: stream ports and packing
// depends on bmre_pkg, bmre_ctrl and bmre_dp
//
//   channel   dir   tdata fields (low bit up)                          side bits
//   s_axis    in    actual_length, new_buttons, delta_x, delta_y       tuser: status
//   m_axis    out   button_index, pressed, held_flags, move_x, move_y  tuser: event_kind,
//                                                                      tlast: last
//   cfg       in    error_limit, written on cfg_we_i                   -
//
// a report word goes through accept, evaluate, one scan step per button and
// a movement step if it carries a movement, in that order; the next word is
// accepted only once the last is done. dropped, ignored and error words end
// after evaluate, a stop notice after its stop step. a stalled output holds
// the scan where it is. reset is asynchronous and needs no clearing pass.

module boot_mouse_report_to_events (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // actual_length[6:0], new_buttons[14:7], delta_x[22:15], delta_y[30:23]
  input  logic [31:0] s_axis_tdata,
  // status[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // button_index[2:0], pressed[3], held_flags[6:4], move_x[14:7], move_y[22:15]
  output logic [23:0] m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  bmre_pkg::ctrl_cmd_t  cmd;
  bmre_pkg::ctrl_stat_t stat;

  logic [bmre_pkg::IndexW-1:0]       button_index;
  logic                              pressed;
  logic [bmre_pkg::HeldW-1:0]        held_flags;
  logic signed [bmre_pkg::DeltaW-1:0] move_x, move_y;

  bmre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bmre_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .status_i        (s_axis_tuser),
    .actual_length_i (s_axis_tdata[6:0]),
    .new_buttons_i   (s_axis_tdata[14:7]),
    .delta_x_i       (s_axis_tdata[22:15]),
    .delta_y_i       (s_axis_tdata[30:23]),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .event_kind_o    (m_axis_tuser),
    .button_index_o  (button_index),
    .pressed_o       (pressed),
    .held_flags_o    (held_flags),
    .move_x_o        (move_x),
    .move_y_o        (move_y),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, move_y, move_x, held_flags, pressed, button_index};

endmodule

[design/bmre_checker.sv]
// port level checks of the boot mouse report decoder and their bind
// depends on bmre_pkg and boot_mouse_report_to_events

module bmre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // set once a stop notice has gone out
  logic stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready &&
                 m_axis_tuser == bmre_pkg::EV_STOP) begin
      stopped_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed while stalled");

  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == bmre_pkg::EV_STOP |-> m_axis_tlast)
    else $error("stop notice not marked last");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !m_axis_tvalid)
    else $error("output word after stop notice");

  a_move_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == bmre_pkg::EV_MOVE |->
      m_axis_tdata[3:0] == 4'd0 && m_axis_tlast)
    else $error("bad movement word");

endmodule

bind boot_mouse_report_to_events bmre_checker u_bmre_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[sim/tb.sv]
// self-checking testbench of boot_mouse_report_to_events: directed table, then random reports
// expected event words come from a behavioral decoder kept inside this file
// depends on bmre_pkg and the design sources only

module tb;
  import bmre_pkg::*;

  localparam logic [1:0] StReserved = 2'd3;
  localparam int SettleCycles = 16;
  localparam int QuietLimit   = 2000;

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_WORD,
    ONE_WORD
  } check_mode_e;

  typedef struct {
    logic [1:0]       status;
    logic [LenW-1:0]  len;
    logic [7:0]       buttons;
    logic [7:0]       dx;
    logic [7:0]       dy;
  } report_t;

  typedef struct {
    event_kind_e       kind;
    logic [IndexW-1:0] idx;
    logic              pressed;
    logic [HeldW-1:0]  held;
    logic [7:0]        mx;
    logic [7:0]        my;
    logic              last;
  } mouse_event_t;

  typedef struct {
    report_t      rpt;
    check_mode_e  mode;
    mouse_event_t word;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // decoder state as the design should hold it
  logic [NumButtons-1:0] seen_buttons = '0;
  logic [HeldW-1:0]      held_mask = '0;
  logic [7:0]            fail_streak = '0;
  logic                  decoder_live = 1'b1;
  logic [7:0]            stop_after = ErrorLimitReset;

  mouse_event_t report_words[$];
  mouse_event_t pending_words[$];
  mouse_event_t want_word;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  rx_hold = 0;
  int unsigned  rx_calm = 0;
  int unsigned  tx_calm = 0;

  boot_mouse_report_to_events u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic mouse_event_t mk_event(input event_kind_e kind,
                                            input logic [IndexW-1:0] idx,
                                            input logic pressed,
                                            input logic [HeldW-1:0] held,
                                            input logic [7:0] mx, input logic [7:0] my);
    mouse_event_t ev;
    ev.kind    = kind;
    ev.idx     = idx;
    ev.pressed = pressed;
    ev.held    = held;
    ev.mx      = mx;
    ev.my      = my;
    ev.last    = 1'b0;
    return ev;
  endfunction

  function automatic stim_row_t dir_row(input logic [1:0] st, input logic [LenW-1:0] len,
                                        input logic [7:0] btn, input logic [7:0] dx,
                                        input logic [7:0] dy, input check_mode_e mode,
                                        input event_kind_e kind, input logic [IndexW-1:0] idx,
                                        input logic pr, input logic [HeldW-1:0] held,
                                        input logic [7:0] mx, input logic [7:0] my);
    stim_row_t row;
    row.rpt.status  = st;
    row.rpt.len     = len;
    row.rpt.buttons = btn;
    row.rpt.dx      = dx;
    row.rpt.dy      = dy;
    row.mode        = mode;
    row.word        = mk_event(kind, idx, pr, held, mx, my);
    row.word.last   = 1'b1;
    return row;
  endfunction

  // works out the event words of one accepted report and advances the state
  task automatic decode_report(input report_t r);
    logic [NumButtons-1:0] now_btn;
    logic [NumButtons-1:0] flipped;
    report_words.delete();
    if (!decoder_live) return;
    if (r.status == ST_OK) begin
      if (r.len < ReportBytes) return;
      fail_streak = '0;
      now_btn = r.buttons[NumButtons-1:0];
      flipped = now_btn ^ seen_buttons;
      for (int i = 0; i < NumButtons; i++) begin
        if (flipped[i]) begin
          // only left, right and middle are qualifiers
          if (i < HeldW) held_mask[i] = now_btn[i];
          report_words.push_back(mk_event(EV_BUTTON, IndexW'(i), now_btn[i], held_mask,
                                          8'h00, 8'h00));
        end
      end
      seen_buttons = now_btn;
      if (r.dx != 8'h00 || r.dy != 8'h00)
        report_words.push_back(mk_event(EV_MOVE, 0, 1'b0, held_mask, r.dx, r.dy));
    end else if (r.status == ST_DETACH) begin
      decoder_live = 1'b0;
      report_words.push_back(mk_event(EV_STOP, 0, 1'b0, held_mask, 8'h00, 8'h00));
    end else begin
      // other error and the unused code both count
      if (fail_streak != 8'hFF) fail_streak++;
      if (fail_streak >= stop_after) begin
        decoder_live = 1'b0;
        report_words.push_back(mk_event(EV_STOP, 0, 1'b0, held_mask, 8'h00, 8'h00));
      end
    end
    if (report_words.size() != 0) report_words[report_words.size() - 1].last = 1'b1;
  endtask

  // mostly short waits, now and then a long one
  function automatic int unsigned stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h00;
      3: return 8'h80;
      4: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // keeps the error streak below the limit so the decoder stays live
  function automatic report_t random_report();
    report_t r;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    r.status  = ST_OK;
    r.len     = 7'($urandom_range(ReportBytes, 8));
    r.dx      = pick_delta();
    r.dy      = pick_delta();
    r.buttons = 8'($urandom);
    case ($urandom_range(0, 3))
      0, 1: r.buttons[NumButtons-1:0] =
              seen_buttons ^ NumButtons'(1 << $urandom_range(0, NumButtons - 1));
      2: r.buttons[NumButtons-1:0] = seen_buttons ^ NumButtons'($urandom);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) r.len = 7'($urandom_range(ReportBytes, 64));
    if (sel < 12) begin
      r.len = 7'($urandom_range(0, ReportBytes - 1));
    end else if (sel >= 80 && int'(fail_streak) + 1 < int'(stop_after)) begin
      r.status = ST_ERROR;
      if ($urandom_range(0, 3) == 0) r.status = StReserved;
      r.len = 7'($urandom_range(0, 64));
    end
    return r;
  endfunction

  task automatic send_report(input report_t r);
    int unsigned gap;
    if (tx_calm != 0) begin
      tx_calm--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      tx_calm = $urandom_range(10, 40);
      gap = 0;
    end else if ($urandom_range(0, 1) == 0) begin
      gap = 0;
    end else begin
      gap = stall_len();
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.status;
    s_axis_tdata  <= {1'b0, r.dy, r.dx, r.buttons, r.len};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic offer_report(input stim_row_t row);
    send_report(row.rpt);
    decode_report(row.rpt);
    if (row.mode == BY_MODEL) begin
      foreach (report_words[i]) pending_words.push_back(report_words[i]);
    end else if (row.mode == ONE_WORD) begin
      pending_words.push_back(row.word);
    end
  endtask

  // holds the sender until every expected word is out and the block has settled
  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    drain_words();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    stop_after = value;
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_calm != 0) begin
        rx_calm <= rx_calm - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        rx_calm <= $urandom_range(20, 120);
      end else if ($urandom_range(0, 3) == 0) begin
        rx_hold <= stall_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected event word: tdata %h tuser %0d tlast %0d",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want_word = pending_words.pop_front();
        compare_field("event_kind", want_word.kind, m_axis_tuser);
        compare_field("button_index", want_word.idx, m_axis_tdata[2:0]);
        compare_field("pressed", want_word.pressed, m_axis_tdata[3]);
        compare_field("held_flags", want_word.held, m_axis_tdata[6:4]);
        compare_field("move_x", want_word.mx, m_axis_tdata[14:7]);
        compare_field("move_y", want_word.my, m_axis_tdata[22:15]);
        compare_field("last", want_word.last, m_axis_tlast);
      end
    end
  end

  // a cycle is quiet when neither side moves a word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t  plan[$];
    stim_row_t  row;
    logic [7:0] lim;

    plan.push_back(dir_row(ST_OK, 7'd3, 8'h00, 8'h00, 8'h00, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    // short reports are dropped whatever they carry
    plan.push_back(dir_row(ST_OK, 7'd2, 8'h1F, 8'h05, 8'hFB, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd0, 8'hFF, 8'h7F, 8'h80, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h01, 8'h00, 8'h00, ONE_WORD,
                           EV_BUTTON, 0, 1, 3'b001, 8'h00, 8'h00));
    // bits above the fifth button change nothing
    plan.push_back(dir_row(ST_OK, 7'd64, 8'hE1, 8'h00, 8'h00, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h1F, 8'h00, 8'h00, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h00, 8'h7F, 8'h80, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h00, 8'h80, 8'h7F, ONE_WORD,
                           EV_MOVE, 0, 0, 3'b000, 8'h80, 8'h7F));
    plan.push_back(dir_row(ST_OK, 7'd5, 8'h00, 8'h01, 8'h00, ONE_WORD,
                           EV_MOVE, 0, 0, 3'b000, 8'h01, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h00, 8'h00, 8'hFF, ONE_WORD,
                           EV_MOVE, 0, 0, 3'b000, 8'h00, 8'hFF));
    plan.push_back(dir_row(ST_ERROR, 7'd0, 8'h00, 8'h00, 8'h00, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(StReserved, 7'd64, 8'hFF, 8'h7F, 8'h7F, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h04, 8'h00, 8'h00, ONE_WORD,
                           EV_BUTTON, 2, 1, 3'b100, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h18, 8'h00, 8'h00, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd4, 8'h02, 8'h03, 8'hFD, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'hA0, 8'h00, 8'h00, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_ERROR, 7'd3, 8'h1F, 8'h7F, 8'h80, NO_WORD,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h07, 8'hAA, 8'h55, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));
    plan.push_back(dir_row(ST_OK, 7'd3, 8'h08, 8'h00, 8'h00, BY_MODEL,
                           EV_BUTTON, 0, 0, 0, 8'h00, 8'h00));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer_report(plan[i]);

    row = plan[0];
    row.mode = BY_MODEL;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: lim = 8'd255;
        1: lim = 8'd1;
        2: lim = 8'($urandom_range(2, 8));
        3: lim = 8'($urandom_range(1, 255));
        default: lim = ErrorLimitReset;
      endcase
      write_limit(lim);
      for (int k = 0; k < 72; k++) begin
        if (k == 36) drain_words();
        row.rpt = random_report();
        offer_report(row);
      end
    end

    // the block stops for good, so this comes last: a detach or an error run
    if ($urandom_range(0, 1) == 0) begin
      row.rpt = random_report();
      row.rpt.status = ST_DETACH;
      offer_report(row);
    end else begin
      case ($urandom_range(0, 2))
        0: lim = 8'd0;
        1: lim = 8'd1;
        default: lim = 8'($urandom_range(2, 6));
      endcase
      write_limit(lim);
      while (decoder_live) begin
        row.rpt = random_report();
        row.rpt.status = ($urandom_range(0, 1) != 0) ? ST_ERROR : StReserved;
        offer_report(row);
      end
    end
    // stopped: everything from here on must vanish
    repeat (8) begin
      row.rpt = random_report();
      row.rpt.status = 2'($urandom_range(0, 3));
      offer_report(row);
    end
    drain_words();

    if (mismatches == 0 && pending_words.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
